### hdl/ntc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants
// Status codes, configuration bundle and fixed-point constants of the
// NTC thermistor (Beta equation) temperature converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

	// Widths fixed by the register map and the result format
	localparam int OHMS_W      = 20;
	localparam int BETA_W      = 14;
	localparam int TEMP_W      = 19;
	localparam int FRAC_W      = 24;
	localparam int LOG_LAT     = FRAC_W + 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_W         = 18;

	// Fixed-point constants
	localparam logic [29:0] LN2_Q30        = 30'd744261118;
	localparam logic [14:0] T0_CENTI       = 15'd29815;
	localparam logic [21:0] BETA_T0_SCALE  = 22'd2981500;
	localparam logic [17:0] TCK_MAX        = 18'd227315;
	localparam logic [TEMP_W-1:0] ZERO_C_CENTI   = 19'd27315;
	localparam logic [TEMP_W-1:0] DEFAULT_CENTI  = 19'd2500;
	localparam logic [TEMP_W-1:0] TEMP_MAX_CENTI = 19'd200000;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DEFAULT  = 2'd1,
		ST_DISABLED = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	// Register indexes
	typedef enum logic [1:0] {
		REG_ENABLE  = 2'd0,
		REG_FIXED   = 2'd1,
		REG_NOMINAL = 2'd2,
		REG_BETA    = 2'd3
	} reg_idx_t;

	// Configuration bundle
	typedef struct packed {
		logic              enabled;
		logic [OHMS_W-1:0] fixed_ohms;
		logic [OHMS_W-1:0] nominal_ohms;
		logic [BETA_W-1:0] beta;
	} cfg_t;

endpackage

### hdl/ntc_adc_to_celsius_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_adc_to_celsius_unit: NTC thermistor ADC code to Celsius converter
// Beta equation in fixed point, 0.01 C result with status, APB registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_ready  | adc_code
//  out     | source    | out_valid/out_ready| temp_centi_c, result_status
//  cfg     | APB slave | psel/penable/pready| paddr, pwdata, prdata
//
//  One sample per cycle while results are taken; a result passes the queue,
//  50 back stages and the output register, a depth set by the 24 squaring
//  stages of the log units and the 18-bit division.
//  Reset loads the register defaults and empties the queue and pipeline.
//  A stalled result freezes the back pipeline; the 4-entry queue keeps
//  taking samples until it fills.
// ----------------------------------------------------------------------------
module ntc_adc_to_celsius_unit import ntc_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ADC_BITS-1:0]      adc_code,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [TEMP_W-1:0] temp_centi_c,
	output logic [1:0]               result_status
);

	localparam int PROD_W = OHMS_W + ADC_BITS;
	localparam int ITEM_W = 2 * PROD_W + 2;

	logic              enabled_q;
	logic [OHMS_W-1:0] fixed_q;
	logic [OHMS_W-1:0] nominal_q;
	logic [BETA_W-1:0] beta_q;
	cfg_t              cfg;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign cfg    = '{enabled: enabled_q, fixed_ohms: fixed_q,
		nominal_ohms: nominal_q, beta: beta_q};

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			fixed_q   <= OHMS_W'(10000);
			nominal_q <= OHMS_W'(10000);
			beta_q    <= BETA_W'(3435);
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_ENABLE:  enabled_q <= pwdata[0];
				REG_FIXED:   fixed_q   <= pwdata[OHMS_W-1:0];
				REG_NOMINAL: nominal_q <= pwdata[OHMS_W-1:0];
				REG_BETA:    beta_q    <= pwdata[BETA_W-1:0];
				default:     ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (idx)
			REG_ENABLE:  prdata = 32'(enabled_q);
			REG_FIXED:   prdata = 32'(fixed_q);
			REG_NOMINAL: prdata = 32'(nominal_q);
			REG_BETA:    prdata = 32'(beta_q);
			default:     prdata = '0;
		endcase
	end

	// Front: classify and form products
	logic              q_full;
	logic              q_push;
	logic              q_empty;
	logic              q_pop;
	logic [PROD_W-1:0] f_num;
	logic [PROD_W-1:0] f_den;
	status_t           f_kind;
	logic [ITEM_W-1:0] q_rdata;
	status_t           h_kind;
	status_t           b_status;

	ntc_front #(.ADC_BITS(ADC_BITS)) u_front (
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.adc_code (adc_code),
		.q_full   (q_full),
		.q_push   (q_push),
		.num      (f_num),
		.den      (f_den),
		.kind     (f_kind)
	);

	ntc_queue #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_kind, f_den, f_num}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign h_kind = status_t'(q_rdata[ITEM_W-1 -: 2]);

	ntc_back #(.PROD_W(PROD_W)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head_valid    (!q_empty),
		.head_num      (q_rdata[PROD_W-1:0]),
		.head_den      (q_rdata[2*PROD_W-1:PROD_W]),
		.head_kind     (h_kind),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.temp_centi_c  (temp_centi_c),
		.result_status (b_status)
	);

	assign result_status = b_status;

endmodule

### hdl/ntc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_queue: short item queue
// Decouples the classifying front from the arithmetic back end.
// ----------------------------------------------------------------------------
module ntc_queue import ntc_pkg::*; #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### hdl/ntc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_front: sample classifier
// Sorts each ADC code into disabled, default or computed cases and forms the
// divider products fixed*code and (full-code)*nominal.
// ----------------------------------------------------------------------------
module ntc_front import ntc_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ADC_BITS-1:0]       adc_code,
	input  logic                      q_full,
	output logic                      q_push,
	output logic [OHMS_W+ADC_BITS-1:0] num,
	output logic [OHMS_W+ADC_BITS-1:0] den,
	output status_t                   kind
);

	localparam int PROD_W = OHMS_W + ADC_BITS;
	localparam logic [ADC_BITS-1:0] FULL = '1;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Form divider products
	assign num = PROD_W'(cfg.fixed_ohms) * PROD_W'(adc_code);
	assign den = PROD_W'(FULL - adc_code) * PROD_W'(cfg.nominal_ohms);

	// Classify the beat
	always_comb begin
		if (!cfg.enabled) begin
			kind = ST_DISABLED;
		end else if (adc_code == '0 || adc_code == FULL || cfg.fixed_ohms == '0
			|| cfg.nominal_ohms == '0) begin
			kind = ST_DEFAULT;
		end else begin
			kind = ST_OK;
		end
	end

endmodule

### hdl/ntc_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_log2: pipelined base-2 logarithm
// Integer part from the top set bit, 24 fraction bits from repeated
// squaring of the Q1.31 mantissa, one squaring per stage.
// ----------------------------------------------------------------------------
module ntc_log2 import ntc_pkg::*; #(
	parameter int X_W = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [X_W-1:0]                x,
	output logic [$clog2(X_W)+FRAC_W-1:0] y
);

	localparam int TOP_W = $clog2(X_W);

	logic [TOP_W-1:0]  top_c;
	logic [TOP_W-1:0]  top_s1;
	logic [X_W-1:0]    x_s1;
	logic [X_W+30:0]   norm;
	logic [31:0]       mant_s [2:LOG_LAT];
	logic [FRAC_W-1:0] frac_s [2:LOG_LAT];
	logic [TOP_W-1:0]  top_s  [2:LOG_LAT];

	// Find the top set bit
	always_comb begin
		top_c = '0;
		for (int i = 0; i < X_W; i++) begin
			if (x[i]) begin
				top_c = TOP_W'(i);
			end
		end
	end

	// Latch the operand and its exponent
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x;
			top_s1 <= top_c;
		end
	end

	// Normalize the mantissa so the top bit lands on bit 31
	assign norm = {x_s1, 31'b0} >> top_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mant_s[2] <= norm[31:0];
			frac_s[2] <= '0;
			top_s[2]  <= top_s1;
		end
	end

	// Square and extract one fraction bit per stage
	for (genvar k = 3; k <= LOG_LAT; k++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] t;

		assign sq = 64'(mant_s[k-1]) * 64'(mant_s[k-1]);
		assign t  = sq[63:31];

		always_ff @(posedge clk) begin
			if (en) begin
				mant_s[k] <= t[32] ? t[32:1] : t[31:0];
				frac_s[k] <= {frac_s[k-1][FRAC_W-2:0], t[32]};
				top_s[k]  <= top_s[k-1];
			end
		end
	end

	assign y = {top_s[LOG_LAT], frac_s[LOG_LAT]};

endmodule

### hdl/ntc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_back: Beta equation back end
// Log ratio, natural log scaling, denominator, restoring division and
// saturation, as one pipeline that advances while the result is free.
// ----------------------------------------------------------------------------
module ntc_back import ntc_pkg::*; #(
	parameter int PROD_W = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     head_valid,
	input  logic [PROD_W-1:0]        head_num,
	input  logic [PROD_W-1:0]        head_den,
	input  status_t                  head_kind,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [TEMP_W-1:0] temp_centi_c,
	output status_t                  result_status
);

	localparam int TOP_W  = $clog2(PROD_W);
	localparam int L2_W   = TOP_W + FRAC_W;
	localparam int LNP_W  = L2_W + 30;
	localparam int LT_W   = L2_W + 15;
	localparam int D_W    = L2_W + 18;
	localparam int DM_W   = D_W - 1;
	localparam int N_W    = BETA_W + 22;
	localparam int B100_W = BETA_W + 7;
	localparam int NPR_W  = N_W + FRAC_W + 1;
	localparam int REM_W  = D_W + Q_W + 1;
	localparam int LAST   = LOG_LAT + 6 + Q_W;

	logic adv;
	logic out_valid_q;
	logic signed [TEMP_W-1:0] temp_q;
	status_t status_q;

	logic [LAST:1] vld_s;
	status_t       tag_s [1:LAST];

	logic [L2_W-1:0] lnum;
	logic [L2_W-1:0] lden;

	// Advance the whole pipeline whenever the output slot frees up
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && head_valid;

	// Track valid beats and their class
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAST-1:1], head_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[1] <= head_kind;
			for (int k = 2; k <= LAST; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	// Logs of both products
	ntc_log2 #(.X_W(PROD_W)) u_log_num (
		.clk (clk),
		.en  (adv),
		.x   (head_num),
		.y   (lnum)
	);

	ntc_log2 #(.X_W(PROD_W)) u_log_den (
		.clk (clk),
		.en  (adv),
		.x   (head_den),
		.y   (lden)
	);

	// Stage 27: log2 difference as sign and magnitude
	logic [L2_W:0]   diff;
	logic [L2_W-1:0] mag_s27;
	logic            neg_s27;

	assign diff = {1'b0, lnum} - {1'b0, lden};

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s27 <= diff[L2_W];
			mag_s27 <= diff[L2_W] ? L2_W'(-diff) : diff[L2_W-1:0];
		end
	end

	// Stage 28: scale by ln2 with rounding, beta products
	logic [LNP_W-1:0]  lnp;
	logic [L2_W-1:0]   lnmag_s28;
	logic              neg_s28;
	logic [B100_W-1:0] b100_s28;
	logic [N_W-1:0]    n_s28;

	assign lnp = LNP_W'(mag_s27) * LNP_W'(LN2_Q30) + (LNP_W'(1) << 29);

	always_ff @(posedge clk) begin
		if (adv) begin
			lnmag_s28 <= lnp[LNP_W-1:30];
			neg_s28   <= neg_s27;
			b100_s28  <= B100_W'(cfg.beta) * B100_W'(100);
			n_s28     <= N_W'(cfg.beta) * N_W'(BETA_T0_SCALE);
		end
	end

	// Stage 29: multiply ln by T0
	logic [LT_W-1:0]   lnt_s29;
	logic              neg_s29;
	logic [B100_W-1:0] b100_s29;
	logic [N_W-1:0]    n_s29;

	always_ff @(posedge clk) begin
		if (adv) begin
			lnt_s29  <= LT_W'(lnmag_s28) * LT_W'(T0_CENTI);
			neg_s29  <= neg_s28;
			b100_s29 <= b100_s28;
			n_s29    <= n_s28;
		end
	end

	// Stage 30: denominator
	logic [D_W-1:0] bd;
	logic [D_W-1:0] d_s30;
	logic [N_W-1:0] n_s30;

	assign bd = D_W'(b100_s29) << FRAC_W;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s30 <= neg_s29 ? (bd - D_W'(lnt_s29)) : (bd + D_W'(lnt_s29));
			n_s30 <= n_s29;
		end
	end

	// Stage 31: rounded dividend, flag a non-positive denominator
	logic [NPR_W-1:0] npr_s31;
	logic [DM_W-1:0]  dm_s31;
	logic             sat_s31;

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s31 <= d_s30[D_W-1] || (d_s30 == '0);
			npr_s31 <= (NPR_W'(n_s30) << FRAC_W) + NPR_W'(d_s30[D_W-1:1]);
			dm_s31  <= d_s30[DM_W-1:0];
		end
	end

	// Stage 32: overflow check ahead of division
	logic [REM_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]   q_s   [0:Q_W];
	logic [DM_W-1:0]  dv_s  [0:Q_W];
	logic             sat_s [0:Q_W];
	logic [REM_W-1:0] dtop;

	assign dtop = REM_W'(dm_s31) << Q_W;

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= REM_W'(npr_s31);
			q_s[0]   <= '0;
			dv_s[0]  <= dm_s31;
			sat_s[0] <= sat_s31 || (REM_W'(npr_s31) >= dtop);
		end
	end

	// Stages 33 to 50: one quotient bit each
	for (genvar j = 1; j <= Q_W; j++) begin : g_div
		logic [REM_W-1:0] ds;
		logic             ge;

		assign ds = REM_W'(dv_s[j-1]) << (Q_W - j);
		assign ge = rem_s[j-1] >= ds;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= ge ? rem_s[j-1] - ds : rem_s[j-1];
				q_s[j]   <= {q_s[j-1][Q_W-2:0], ge};
				dv_s[j]  <= dv_s[j-1];
				sat_s[j] <= sat_s[j-1];
			end
		end
	end

	// Final selection into the output register
	logic                     over;
	logic signed [TEMP_W-1:0] temp_c;
	status_t                  status_c;

	assign over = sat_s[Q_W] || (q_s[Q_W] > TCK_MAX);

	always_comb begin
		case (tag_s[LAST])
			ST_OK: begin
				if (over) begin
					temp_c   = TEMP_MAX_CENTI;
					status_c = ST_SAT;
				end else begin
					temp_c   = TEMP_W'(q_s[Q_W]) - ZERO_C_CENTI;
					status_c = ST_OK;
				end
			end
			default: begin
				temp_c   = DEFAULT_CENTI;
				status_c = tag_s[LAST];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_q   <= temp_c;
			status_q <= status_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign temp_centi_c  = temp_q;
	assign result_status = status_q;

	// Default codes always carry 25 C
	a_default_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_DEFAULT || status_q == ST_DISABLED)
		|-> temp_q == DEFAULT_CENTI)
		else $error("default status without 25 C");

	// Saturation pins the upper limit
	a_sat_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_SAT |-> temp_q == TEMP_MAX_CENTI)
		else $error("saturated status without limit value");

	// Computed results stay within range
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_OK
		|-> (temp_q <= $signed(TEMP_MAX_CENTI)) && (temp_q >= -$signed(ZERO_C_CENTI)))
		else $error("computed result out of range");

	// A stalled result holds until taken
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(temp_q) && $stable(status_q))
		else $error("result changed under stall");

endmodule
